// File: rtl/tkss_pkg.sv
`default_nettype none

package tkss_pkg;

	// Heap geometry
	localparam int K_ENTRIES = 1024;
	localparam int ADDR_W    = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
	localparam int HCNT_W    = $clog2(K_ENTRIES + 1);
	// child index needs room for 2*pos+2
	localparam int IDX_W     = ADDR_W + 2;

	// Field widths
	localparam int SCORE_W = 14;
	localparam int ERR_W   = 12;
	localparam int DEPTH_W = 6;
	localparam int KEPT_W  = 11;

	// Opcodes
	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Register map (word index)
	localparam int          APB_ADDR_W        = 3;
	localparam int          APB_DATA_W        = 32;
	localparam logic [0:0]  REG_SCORE_CEILING = 1'b0;
	localparam logic [SCORE_W-1:0] CEIL_RESET = 14'h3FFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_CMP,
		ST_DN,
		ST_DN_R,
		ST_DN_CMP,
		ST_LAST,
		ST_OUT
	} tkss_state_t;

	typedef struct packed {
		logic               opcode;
		logic [SCORE_W-1:0] score;
	} tkss_req_t;

	typedef struct packed {
		logic               accepted;
		logic [SCORE_W-1:0] drained_score;
		logic               drained_valid;
		logic [KEPT_W-1:0]  kept_count;
	} tkss_result_t;

endpackage

`default_nettype wire

// File: rtl/tkss_ram.sv
`default_nettype none

module tkss_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/tkss_heap.sv
`default_nettype none

module tkss_heap (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	input  wire tkss_pkg::tkss_req_t          req,
	output logic                              req_stall,
	input  wire logic [tkss_pkg::SCORE_W-1:0] score_ceiling,
	output logic                              res_valid,
	output tkss_pkg::tkss_result_t            res,
	input  wire logic                         res_free
);

	import tkss_pkg::*;

	tkss_state_t state_q, state_d;

	logic [HCNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0]  pos_q, pos_d;
	logic [SCORE_W-1:0] val_q, val_d;
	logic [SCORE_W-1:0] lval_q, lval_d;
	logic [SCORE_W-1:0] root_q;
	logic               accepted_q, accepted_d;
	logic [SCORE_W-1:0] drained_q, drained_d;
	logic               dvalid_q, dvalid_d;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [SCORE_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [SCORE_W-1:0] mem_rdata;

	// Heap storage
	tkss_ram #(
		.WIDTH (SCORE_W),
		.DEPTH (K_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Index arithmetic
	logic [IDX_W-1:0]  left_idx, right_idx, cnt_ext;
	logic [ADDR_W-1:0] parent_pos;
	logic [HCNT_W-1:0] count_dec;
	logic              has_left, has_right, full;

	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + IDX_W'(1);
	assign cnt_ext    = IDX_W'(count_q);
	assign has_left   = left_idx < cnt_ext;
	assign has_right  = right_idx < cnt_ext;
	assign parent_pos = (pos_q - ADDR_W'(1)) >> 1;
	assign count_dec  = count_q - HCNT_W'(1);
	assign full       = count_q >= HCNT_W'(K_ENTRIES);

	// Compares
	logic offer_reject, up_stop, l_gt, r_gt;
	logic [SCORE_W-1:0] best_lv;

	assign offer_reject = (req.score > score_ceiling) || (full && (req.score > root_q));
	assign up_stop      = mem_rdata >= val_q;
	assign l_gt         = lval_q > val_q;
	assign best_lv      = l_gt ? lval_q : val_q;
	assign r_gt         = has_right && (mem_rdata > best_lv);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.opcode == OP_OFFER) begin
						if (offer_reject) state_d = ST_OUT;
						else if (full)    state_d = ST_DN;
						else              state_d = ST_UP;
					end else begin
						if (count_q > HCNT_W'(1)) state_d = ST_LAST;
						else                      state_d = ST_OUT;
					end
				end
			end
			ST_UP:     state_d = (pos_q == '0) ? ST_OUT : ST_UP_CMP;
			ST_UP_CMP: state_d = up_stop ? ST_OUT : ST_UP;
			ST_DN:     state_d = has_left ? ST_DN_R : ST_OUT;
			ST_DN_R:   state_d = ST_DN_CMP;
			ST_DN_CMP: state_d = (r_gt || l_gt) ? ST_DN : ST_OUT;
			ST_LAST:   state_d = ST_DN;
			ST_OUT:    state_d = res_free ? ST_IDLE : ST_OUT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath and memory control; the sequencer never reads an entry in the
	// cycle after writing it, so no forwarding is needed
	always_comb begin
		count_d    = count_q;
		pos_d      = pos_q;
		val_d      = val_q;
		lval_d     = lval_q;
		accepted_d = accepted_q;
		drained_d  = drained_q;
		dvalid_d   = dvalid_q;
		mem_we     = 1'b0;
		mem_waddr  = pos_q;
		mem_wdata  = val_q;
		mem_raddr  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					accepted_d = 1'b0;
					drained_d  = '0;
					dvalid_d   = 1'b0;
					if (req.opcode == OP_OFFER) begin
						if (!offer_reject) begin
							accepted_d = 1'b1;
							val_d      = req.score;
							if (full) begin
								pos_d = '0;
							end else begin
								pos_d   = ADDR_W'(count_q);
								count_d = count_q + HCNT_W'(1);
							end
						end
					end else if (count_q != '0) begin
						// pop root, fetch last entry to refill it
						drained_d = root_q;
						dvalid_d  = 1'b1;
						count_d   = count_dec;
						mem_raddr = ADDR_W'(count_dec);
						pos_d     = '0;
					end
				end
			end
			ST_UP: begin
				if (pos_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_raddr = parent_pos;
				end
			end
			ST_UP_CMP: begin
				mem_we = 1'b1;
				if (!up_stop) begin
					mem_wdata = mem_rdata;
					pos_d     = parent_pos;
				end
			end
			ST_DN: begin
				if (has_left) begin
					mem_raddr = ADDR_W'(left_idx);
				end else begin
					mem_we = 1'b1;
				end
			end
			ST_DN_R: begin
				lval_d    = mem_rdata;
				mem_raddr = ADDR_W'(right_idx);
			end
			ST_DN_CMP: begin
				mem_we = 1'b1;
				if (r_gt) begin
					mem_wdata = mem_rdata;
					pos_d     = ADDR_W'(right_idx);
				end else if (l_gt) begin
					mem_wdata = lval_q;
					pos_d     = ADDR_W'(left_idx);
				end
			end
			ST_LAST: begin
				val_d = mem_rdata;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Payload registers; root mirrors entry zero
	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		val_q      <= val_d;
		lval_q     <= lval_d;
		accepted_q <= accepted_d;
		drained_q  <= drained_d;
		dvalid_q   <= dvalid_d;
		if (mem_we && (mem_waddr == '0)) begin
			root_q <= mem_wdata;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res       = '{accepted:      accepted_q,
	                     drained_score: drained_q,
	                     drained_valid: dvalid_q,
	                     kept_count:    KEPT_W'(count_q)};

endmodule

`default_nettype wire

// File: rtl/bounded_top_k_smallest_selector.sv
// Bounded top-K smallest selector.
// Keeps the K smallest scores offered, in a max-heap held in one 1024 x 14
// synchronous RAM. Each input request is either an offer (opcode 0) with
// black_error, white_error and node_depth, scored as black + white + 8*depth
// in sixteenths, or a drain (opcode 1) that pops the largest kept score.
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low. Exactly one result request follows each input request.
// A rejected offer, or a drain that leaves the heap empty, goes straight to
// the result. An insertion sifts up; a drain, or a replace on a full heap,
// sifts down. The single RAM read port paces each sift: at most one entry
// is read per cycle.
// One request at a time; the next is taken the cycle after the result enters
// the output register, even under a stall.
// A stalled result holds its value; the core waits while the output
// register is occupied and stalled. Reset empties the heap (count to zero)
// at once and sets score_ceiling to 16383; the RAM needs no clearing.
// score_ceiling is at APB byte address 0; write it only while idle.
`default_nettype none

module bounded_top_k_smallest_selector (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// APB configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tkss_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [tkss_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [tkss_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            opcode,
	input  wire logic [tkss_pkg::ERR_W-1:0]      black_error,
	input  wire logic [tkss_pkg::ERR_W-1:0]      white_error,
	input  wire logic [tkss_pkg::DEPTH_W-1:0]    node_depth,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 accepted,
	output logic      [tkss_pkg::SCORE_W-1:0]    drained_score,
	output logic                                 drained_valid,
	output logic      [tkss_pkg::KEPT_W-1:0]     kept_count
);

	import tkss_pkg::*;

	logic [SCORE_W-1:0] ceiling_q;
	logic [0:0]         reg_idx;
	logic               cfg_wr;

	// Config register
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEIL_RESET;
		end else if (cfg_wr && (reg_idx == REG_SCORE_CEILING)) begin
			ceiling_q <= pwdata[SCORE_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SCORE_CEILING: prdata = APB_DATA_W'(ceiling_q);
			default:           prdata = '0;
		endcase
	end

	// Score: both errors plus half the depth, all in sixteenths
	tkss_req_t req;
	assign req.opcode = opcode;
	assign req.score  = SCORE_W'(black_error) + SCORE_W'(white_error)
	                  + SCORE_W'({node_depth, 3'b000});

	tkss_result_t res;
	logic         res_valid;
	logic         res_free;
	logic         out_valid_q;
	tkss_result_t out_q;

	tkss_heap u_heap (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (in_valid),
		.req           (req),
		.req_stall     (in_stall),
		.score_ceiling (ceiling_q),
		.res_valid     (res_valid),
		.res           (res),
		.res_free      (res_free)
	);

	// Output register
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = out_q.accepted;
	assign drained_score = out_q.drained_score;
	assign drained_valid = out_q.drained_valid;
	assign kept_count    = out_q.kept_count;

endmodule

`default_nettype wire

// File: rtl/tkss_checker.sv
`default_nettype none

module tkss_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic                         accepted,
	input wire logic [tkss_pkg::SCORE_W-1:0] drained_score,
	input wire logic                         drained_valid,
	input wire logic [tkss_pkg::KEPT_W-1:0]  kept_count
);

	import tkss_pkg::*;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted)
			&& $stable(drained_score) && $stable(drained_valid) && $stable(kept_count))
		else $error("stalled result changed");

	// an offer never pops and a drain never accepts
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(accepted && drained_valid))
		else $error("accepted and drained_valid both set");

	// score only reported with a pop
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drained_valid |-> drained_score == '0)
		else $error("drained_score nonzero without pop");

	// heap never exceeds its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kept_count <= KEPT_W'(K_ENTRIES))
		else $error("kept_count above capacity");

endmodule

bind bounded_top_k_smallest_selector tkss_checker u_tkss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.accepted      (accepted),
	.drained_score (drained_score),
	.drained_valid (drained_valid),
	.kept_count    (kept_count)
);

`default_nettype wire

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tkss_pkg::*;

	localparam int MAX_SCORE      = 2 * 4095 + 8 * 63;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_LATENCY  = 40;
	localparam int HOLD_CYCLES    = 250;
	localparam logic [APB_ADDR_W-1:0] CEIL_ADDR = APB_ADDR_W'(4 * int'(REG_SCORE_CEILING));

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  psel        = 1'b0;
	logic                  penable     = 1'b0;
	logic                  pwrite      = 1'b0;
	logic [APB_ADDR_W-1:0] paddr       = '0;
	logic [APB_DATA_W-1:0] pwdata      = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  opcode      = OP_OFFER;
	logic [ERR_W-1:0]      black_error = '0;
	logic [ERR_W-1:0]      white_error = '0;
	logic [DEPTH_W-1:0]    node_depth  = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  accepted;
	logic [SCORE_W-1:0]    drained_score;
	logic                  drained_valid;
	logic [KEPT_W-1:0]     kept_count;

	bounded_top_k_smallest_selector dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .opcode, .black_error, .white_error, .node_depth,
		.out_valid, .out_stall, .accepted, .drained_score, .drained_valid, .kept_count
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mirror of the kept scores, same max-heap layout as the block
	logic [SCORE_W-1:0] kept_heap [K_ENTRIES];
	int                 kept_size   = 0;
	logic [SCORE_W-1:0] ceiling_now = CEIL_RESET;
	logic [SCORE_W-1:0] mid_ceiling;

	tkss_result_t heap_results_due [$];

	int mismatch_count  = 0;
	int results_checked = 0;
	int requests_sent   = 0;
	int offers_kept     = 0;
	int scores_drained  = 0;
	int full_offers     = 0;
	int peak_size       = 0;
	int quiet_cycles    = 0;

	int          idle_pct  = 0;
	int          stall_pct = 0;
	int unsigned recv_cycle = 0;
	int unsigned hold_until = 0;

	typedef struct {
		logic               op;
		logic [ERR_W-1:0]   blk;
		logic [ERR_W-1:0]   wht;
		logic [DEPTH_W-1:0] dep;
		bit                 known;
		tkss_result_t       want;
	} drill_row_t;

	// known results: {accepted, drained_score, drained_valid, kept_count}
	drill_row_t drill_rows [16] = '{
		'{OP_DRAIN, 12'h000, 12'h000, 6'h00, 1'b1, tkss_result_t'({1'b0, 14'd0, 1'b0, 11'd0})},
		'{OP_OFFER, 12'hFFF, 12'hFFF, 6'h3F, 1'b1, tkss_result_t'({1'b1, 14'd0, 1'b0, 11'd1})},
		'{OP_DRAIN, 12'h000, 12'h000, 6'h00, 1'b1,
			tkss_result_t'({1'b0, 14'd8694, 1'b1, 11'd0})},
		'{OP_DRAIN, 12'hFFF, 12'hFFF, 6'h3F, 1'b1, tkss_result_t'({1'b0, 14'd0, 1'b0, 11'd0})},
		'{OP_OFFER, 12'h000, 12'h000, 6'h00, 1'b1, tkss_result_t'({1'b1, 14'd0, 1'b0, 11'd1})},
		'{OP_OFFER, 12'hFFF, 12'h000, 6'h00, 1'b1, tkss_result_t'({1'b1, 14'd0, 1'b0, 11'd2})},
		'{OP_OFFER, 12'h000, 12'hFFF, 6'h00, 1'b1, tkss_result_t'({1'b1, 14'd0, 1'b0, 11'd3})},
		'{OP_OFFER, 12'h000, 12'h000, 6'h3F, 1'b1, tkss_result_t'({1'b1, 14'd0, 1'b0, 11'd4})},
		'{OP_OFFER, 12'hAAA, 12'h555, 6'h2A, 1'b0, '0},
		'{OP_OFFER, 12'h555, 12'hAAA, 6'h15, 1'b0, '0},
		'{OP_OFFER, 12'h800, 12'h001, 6'h20, 1'b0, '0},
		'{OP_OFFER, 12'h000, 12'h000, 6'h00, 1'b0, '0},
		'{OP_DRAIN, 12'h5A5, 12'hA5A, 6'h2A, 1'b0, '0},
		'{OP_DRAIN, 12'h000, 12'h000, 6'h00, 1'b0, '0},
		'{OP_DRAIN, 12'h000, 12'h000, 6'h00, 1'b0, '0},
		'{OP_OFFER, 12'h123, 12'h456, 6'h01, 1'b0, '0}
	};

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// push the root value down until the heap order holds again
	function automatic void settle_root();
		int                 pos;
		int                 left;
		int                 right;
		int                 big;
		logic [SCORE_W-1:0] t;
		pos = 0;
		while (1) begin
			left  = 2 * pos + 1;
			right = left + 1;
			big   = pos;
			if (left < kept_size && kept_heap[left] > kept_heap[big])
				big = left;
			if (right < kept_size && kept_heap[right] > kept_heap[big])
				big = right;
			if (big == pos)
				break;
			t              = kept_heap[pos];
			kept_heap[pos] = kept_heap[big];
			kept_heap[big] = t;
			pos            = big;
		end
	endfunction

	// apply one request to the mirror heap and return the result it yields
	function automatic tkss_result_t score_request(input logic op,
			input logic [ERR_W-1:0] blk, input logic [ERR_W-1:0] wht,
			input logic [DEPTH_W-1:0] dep);
		tkss_result_t       r;
		int                 score;
		int                 pos;
		int                 parent;
		logic [SCORE_W-1:0] t;
		r = '0;
		if (op == OP_OFFER) begin
			score = int'(blk) + int'(wht) + 8 * int'(dep);
			if (score > int'(ceiling_now)) begin
				r.accepted = 1'b0;
			end else if (kept_size >= K_ENTRIES && score > int'(kept_heap[0])) begin
				r.accepted = 1'b0;
			end else if (kept_size >= K_ENTRIES) begin
				// full heap: new score replaces the largest
				kept_heap[0] = SCORE_W'(score);
				settle_root();
				r.accepted = 1'b1;
			end else begin
				pos            = kept_size;
				kept_heap[pos] = SCORE_W'(score);
				kept_size++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (kept_heap[parent] >= kept_heap[pos])
						break;
					t                 = kept_heap[parent];
					kept_heap[parent] = kept_heap[pos];
					kept_heap[pos]    = t;
					pos               = parent;
				end
				r.accepted = 1'b1;
			end
		end else if (kept_size > 0) begin
			r.drained_score = kept_heap[0];
			r.drained_valid = 1'b1;
			kept_size--;
			kept_heap[0] = kept_heap[kept_size];
			settle_root();
		end
		r.kept_count = KEPT_W'(kept_size);
		return r;
	endfunction

	// pick error terms and depth that add up to the given score
	function automatic void split_score(input int target, output logic [ERR_W-1:0] blk,
			output logic [ERR_W-1:0] wht, output logic [DEPTH_W-1:0] dep);
		int dmin;
		int dmax;
		int rest;
		int lo;
		int hi;
		dmin = (target > 8190) ? (target - 8190 + 7) / 8 : 0;
		dmax = (target / 8 < 63) ? target / 8 : 63;
		dep  = DEPTH_W'($urandom_range(dmax, dmin));
		rest = target - 8 * int'(dep);
		lo   = (rest > 4095) ? rest - 4095 : 0;
		hi   = (rest < 4095) ? rest : 4095;
		blk  = ERR_W'($urandom_range(hi, lo));
		wht  = ERR_W'(rest - int'(blk));
	endfunction

	task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CEIL_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// offer one request, wait for the handshake, then log what should come back
	task automatic push_request(input logic op, input logic [ERR_W-1:0] blk,
			input logic [ERR_W-1:0] wht, input logic [DEPTH_W-1:0] dep,
			input bit known, input tkss_result_t want);
		tkss_result_t predicted;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		black_error <= blk;
		white_error <= wht;
		node_depth  <= dep;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == OP_OFFER && kept_size >= K_ENTRIES)
			full_offers++;
		predicted = score_request(op, blk, wht, dep);
		heap_results_due = {heap_results_due, (known ? want : predicted)};
		requests_sent++;
		offers_kept    += predicted.accepted;
		scores_drained += predicted.drained_valid;
		if (kept_size > peak_size)
			peak_size = kept_size;
	endtask

	// mix of drains and offers; offers lean on the ceiling and the current max
	task automatic run_phase(input int count, input int drain_pct);
		int                 target;
		int                 pick;
		logic [ERR_W-1:0]   blk;
		logic [ERR_W-1:0]   wht;
		logic [DEPTH_W-1:0] dep;
		repeat (count) begin
			blk = ERR_W'($urandom_range(4095));
			wht = ERR_W'($urandom_range(4095));
			dep = DEPTH_W'($urandom_range(63));
			if ($urandom_range(99) < drain_pct) begin
				push_request(OP_DRAIN, blk, wht, dep, 1'b0, '0);
			end else begin
				pick   = $urandom_range(99);
				target = -1;
				if (pick < 12)
					target = int'(ceiling_now);
				else if (pick < 20)
					target = int'(ceiling_now) + 1;
				else if (pick < 35 && kept_size > 0)
					target = int'(kept_heap[0]);
				else if (pick < 45 && kept_size > 0)
					target = $urandom_range(int'(kept_heap[0]));
				if (target >= 0 && target <= MAX_SCORE)
					split_score(target, blk, wht, dep);
				push_request(OP_OFFER, blk, wht, dep, 1'b0, '0);
			end
		end
	endtask

	// register writes only once the block has gone quiet
	task automatic set_ceiling(input logic [SCORE_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		in_valid <= 1'b0;
		while (heap_results_due.size() != 0)
			@(posedge clk);
		apb_access(1'b1, APB_DATA_W'(value), rd);
		ceiling_now = value;
		apb_access(1'b0, '0, rd);
		if (rd[SCORE_W-1:0] !== value)
			report_mismatch($sformatf("score_ceiling read %0d want %0d",
				rd[SCORE_W-1:0], value));
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		out_stall <= (recv_cycle < hold_until) ||
			(stall_pct != 0 && $urandom_range(99) < stall_pct);
		recv_cycle++;
	end

	// result checking and progress watchdog
	always @(posedge clk) begin : result_check
		tkss_result_t want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end else if (out_valid && !out_stall) begin
				if (heap_results_due.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					want = heap_results_due.pop_front();
					check_field("accepted", accepted, want.accepted);
					check_field("drained_score", drained_score, want.drained_score);
					check_field("drained_valid", drained_valid, want.drained_valid);
					check_field("kept_count", kept_count, want.kept_count);
					results_checked++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [APB_DATA_W-1:0] rd;
		bit                    paused;
		paused      = 1'b0;
		mid_ceiling = SCORE_W'($urandom_range(8000, 1000));
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the ceiling
		apb_access(1'b0, '0, rd);
		if (rd[SCORE_W-1:0] !== CEIL_RESET)
			report_mismatch($sformatf("score_ceiling after reset %0d", rd[SCORE_W-1:0]));

		// directed rows
		foreach (drill_rows[i])
			push_request(drill_rows[i].op, drill_rows[i].blk, drill_rows[i].wht,
				drill_rows[i].dep, drill_rows[i].known, drill_rows[i].want);

		// ceiling at the largest score, no idling, long receiver hold-off
		set_ceiling(SCORE_W'(MAX_SCORE));
		run_phase(10, 10);
		hold_until = recv_cycle + HOLD_CYCLES;
		run_phase(60, 10);

		// mid ceiling, sender idles
		idle_pct = 47;
		set_ceiling(mid_ceiling);
		run_phase(50, 30);

		// zero ceiling, receiver stalls
		idle_pct  = 0;
		stall_pct = 47;
		set_ceiling('0);
		run_phase(40, 25);

		// top ceiling, both sides idle: fill the heap, work it full, then drain
		idle_pct  = 27;
		stall_pct = 27;
		set_ceiling(SCORE_W'(16383));
		while (kept_size < K_ENTRIES) begin
			if (kept_size == K_ENTRIES / 2 && !paused) begin
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (heap_results_due.size() != 0);
				paused = 1'b1;
			end
			run_phase(1, 0);
		end
		run_phase(50, 10);
		run_phase(30, 100);

		in_valid <= 1'b0;
		while (heap_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_LATENCY)
			@(posedge clk);

		$display("Ran %0d requests: %0d offers kept, %0d scores drained, heap peak %0d of %0d",
			requests_sent, offers_kept, scores_drained, peak_size, K_ENTRIES);
		$display("Ceilings 16383, %0d, %0d and 0; %0d offers on a full heap; %0d results checked",
			MAX_SCORE, mid_ceiling, full_offers, results_checked);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/tkss_pkg.sv
rtl/tkss_ram.sv
rtl/tkss_heap.sv
rtl/bounded_top_k_smallest_selector.sv
rtl/tkss_checker.sv
sim/testbench.sv
